FILE: src/baro_temp_pressure_compensation_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the barometric compensation block
// Clocked assertion wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_MACROS_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_MACROS_SVH

// property checked on every rising edge, off while in reset
`define BTPC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("btpc assertion failed");

// condition that must never be seen
`define BTPC_NEVER(lbl, cond) \
	`BTPC_ASSERT(lbl, !(cond))

`endif

FILE: src/btpc_pkg.sv
// ----------------------------------------------------------------------------
// btpc_pkg
// Types and constants shared by the barometric compensation modules.
// ----------------------------------------------------------------------------
package btpc_pkg;

	localparam int RAW_W    = 20;
	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 32;
	localparam int QDEPTH   = 2;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int QCNT_W   = $clog2(QDEPTH + 1);
	localparam int DIV_STAGES = 64;

	localparam logic [16:0] FINE_OFFSET = 17'd128000;
	localparam logic [11:0] DIV_SCALE   = 12'd3125;
	localparam logic [20:0] RAW_FULL    = 21'd1048576;
	localparam logic [31:0] ROUND_HALF  = 32'd128;
	localparam logic [63:0] OFFSET_47   = 64'h0000_8000_0000_0000;

	// register map, word index
	typedef enum logic [2:0] {
		REG_T1    = 3'd0,
		REG_T2_T3 = 3'd1,
		REG_P1    = 3'd2,
		REG_P2_P3 = 3'd3,
		REG_P4_P5 = 3'd4,
		REG_P6_P7 = 3'd5,
		REG_P8_P9 = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [RAW_W-1:0] raw_pressure;
		logic [RAW_W-1:0] raw_temperature;
	} item_t;

	typedef struct packed {
		logic [15:0]        t1;
		logic signed [15:0] t2;
		logic signed [15:0] t3;
		logic [15:0]        p1;
		logic signed [15:0] p2;
		logic signed [15:0] p3;
		logic signed [15:0] p4;
		logic signed [15:0] p5;
		logic signed [15:0] p6;
		logic signed [15:0] p7;
		logic signed [15:0] p8;
		logic signed [15:0] p9;
	} cal_t;

	// side band riding along the divider
	typedef struct packed {
		logic signed [31:0] temp;
		logic               zero;
		logic               neg;
	} side_t;

endpackage

FILE: src/btpc_front.sv
// ----------------------------------------------------------------------------
// btpc_front
// Input side: accepts sample pairs into a short queue ahead of the datapath.
// ----------------------------------------------------------------------------
module btpc_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  btpc_pkg::item_t  in_item,
	input  logic             take,
	output logic             head_valid,
	output btpc_pkg::item_t  head_item
);

	btpc_pkg::item_t                    mem_q [btpc_pkg::QDEPTH];
	logic [btpc_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [btpc_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [btpc_pkg::QCNT_W-1:0]        cnt_q;
	logic                               push;
	logic                               pop;

	assign in_ready   = (cnt_q != btpc_pkg::QCNT_W'(btpc_pkg::QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_item  = mem_q[rd_ptr_q];
	assign push       = in_valid & in_ready;
	assign pop        = take & head_valid;

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == btpc_pkg::QPTR_W'(btpc_pkg::QDEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == btpc_pkg::QPTR_W'(btpc_pkg::QDEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: src/btpc_div.sv
// ----------------------------------------------------------------------------
// btpc_div
// Pipelined unsigned 64-bit restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module btpc_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [63:0]       in_num,
	input  logic [63:0]       in_den,
	input  btpc_pkg::side_t   in_side,
	output logic              out_valid,
	output logic [63:0]       out_quo,
	output btpc_pkg::side_t   out_side
);

	localparam int N = btpc_pkg::DIV_STAGES;

	logic [63:0]      rem_s  [N];
	logic [63:0]      nq_s   [N];
	logic [63:0]      den_s  [N];
	btpc_pkg::side_t  side_s [N];
	logic             vld_s  [N];

	for (genvar g = 0; g < N; g++) begin : g_stage
		logic [63:0]     rem_in;
		logic [63:0]     nq_in;
		logic [63:0]     den_in;
		btpc_pkg::side_t side_in;
		logic            vld_in;
		logic [64:0]     trial;
		logic            fits;

		if (g == 0) begin : g_first
			assign rem_in  = '0;
			assign nq_in   = in_num;
			assign den_in  = in_den;
			assign side_in = in_side;
			assign vld_in  = in_valid;
		end else begin : g_next
			assign rem_in  = rem_s[g-1];
			assign nq_in   = nq_s[g-1];
			assign den_in  = den_s[g-1];
			assign side_in = side_s[g-1];
			assign vld_in  = vld_s[g-1];
		end

		// bring down next numerator bit, try the subtract
		assign trial = {rem_in, nq_in[63]};
		assign fits  = (trial >= {1'b0, den_in});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g]  <= fits ? 64'(trial - {1'b0, den_in}) : trial[63:0];
				nq_s[g]   <= {nq_in[62:0], fits};
				den_s[g]  <= den_in;
				side_s[g] <= side_in;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= vld_in;
			end
		end
	end

	assign out_valid = vld_s[N-1];
	assign out_quo   = nq_s[N-1];
	assign out_side  = side_s[N-1];

endmodule

FILE: src/btpc_back.sv
// ----------------------------------------------------------------------------
// btpc_back
// Compensation datapath: temperature, pressure terms, division, output reg.
// ----------------------------------------------------------------------------
module btpc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  btpc_pkg::cal_t    cal,
	input  logic              in_valid,
	input  btpc_pkg::item_t   in_item,
	output logic              take,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [31:0]       out_temp,
	output logic [31:0]       out_pres,
	output logic              out_pvalid
);

	logic en;

	// stage valids
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;
	logic v_s12, v_s13, v_s14, v_s15, v_s16, v_s17, out_v_q;

	// temperature path
	logic signed [17:0] x_d;
	logic signed [16:0] d_d;
	logic signed [33:0] ma_s1, mdd_s1;
	logic signed [31:0] a_d, dd_sh;
	logic signed [31:0] a_s2;
	logic signed [35:0] mb_s2;
	logic signed [31:0] b_d, fine_s3;
	logic [31:0]        f5_d;
	logic signed [31:0] temp_d, temp_s4, temp_s5, temp_s6, temp_s7;
	logic signed [31:0] temp_s8, temp_s9, temp_s10;
	logic signed [33:0] v1_d, v1_s4;
	logic [19:0]        rp_s1, rp_s2, rp_s3, rp_s4, rp_s5, rp_s6, rp_s7;

	// pressure terms
	logic signed [67:0] sq_s5;
	logic signed [49:0] m5_s5, m2_s5, m5_s6, m2_s6;
	logic signed [48:0] ml6_s6, ml3_s6;
	logic [31:0]        mh6_s6, mh3_s6;
	logic [63:0]        v2_s7, u3_s7, m2sh_s7;
	logic signed [63:0] u3_sh;
	logic [20:0]        p0_d;
	logic [63:0]        w_s8, num_s8;
	logic [47:0]        wl_s9;
	logic [31:0]        wh_s9, nh_s9;
	logic [43:0]        nl_s9;
	logic [63:0]        wp_d;
	logic signed [63:0] den_s10;
	logic [63:0]        num_s10;
	logic [63:0]        an_s11, ad_s11;
	btpc_pkg::side_t    side_s11;

	// divider outputs and post terms
	logic               dv_valid;
	logic [63:0]        dv_quo;
	btpc_pkg::side_t    dv_side;
	logic [63:0]        p_d;
	logic [63:0]        p_s12, p_s13, p_s14, p_s15, p_s16;
	logic signed [63:0] qq_d;
	logic [63:0]        qq_s12;
	btpc_pkg::side_t    side_s12, side_s13, side_s14, side_s15, side_s16, side_s17;
	logic [63:0]        lolo_s13;
	logic [31:0]        hilo_s13, ph8_s13, h9_s15;
	logic signed [48:0] pl8_s13, l9_s15;
	logic [63:0]        p8sum_d, p9sum_d;
	logic signed [63:0] v2p_d, v1p_d;
	logic [63:0]        sqq_s14, v2p_s14, v2p_s15, v2p_s16, v1p_s16, sum_s17;
	logic signed [63:0] sum_sh;
	logic [63:0]        r_d;
	logic [31:0]        sat_d;

	assign en   = !out_v_q || out_ready;
	assign take = en;

	// temperature combinational pieces
	assign x_d    = $signed({1'b0, in_item.raw_temperature[19:3]}) -
		$signed({1'b0, cal.t1, 1'b0});
	assign d_d    = $signed({1'b0, in_item.raw_temperature[19:4]}) - $signed({1'b0, cal.t1});
	assign a_d    = $signed(ma_s1[31:0]) >>> 11;
	assign dd_sh  = $signed(mdd_s1[31:0]) >>> 12;
	assign b_d    = $signed(mb_s2[31:0]) >>> 14;
	assign f5_d   = {fine_s3[29:0], 2'b00} + fine_s3 + btpc_pkg::ROUND_HALF;
	assign temp_d = $signed(f5_d) >>> 8;
	assign v1_d   = $signed({{2{fine_s3[31]}}, fine_s3}) -
		$signed({17'd0, btpc_pkg::FINE_OFFSET});

	// pressure combinational pieces
	assign u3_sh  = $signed(u3_s7) >>> 8;
	assign p0_d   = btpc_pkg::RAW_FULL - {1'b0, rp_s7};
	assign wp_d   = {wh_s9, 32'd0} + {16'd0, wl_s9};

	// post-division pieces
	assign p_d     = dv_side.neg ? 64'd0 - dv_quo : dv_quo;
	assign qq_d    = $signed(p_d) >>> 13;
	assign p8sum_d = {{15{pl8_s13[48]}}, pl8_s13} + {ph8_s13, 32'd0};
	assign v2p_d   = $signed(p8sum_d) >>> 19;
	assign p9sum_d = {{15{l9_s15[48]}}, l9_s15} + {h9_s15, 32'd0};
	assign v1p_d   = $signed(p9sum_d) >>> 25;
	assign sum_sh  = $signed(sum_s17) >>> 8;
	assign r_d     = sum_sh + ({{48{cal.p7[15]}}, cal.p7} << 4);
	assign sat_d   = r_d[63] ? 32'd0 : ((|r_d[62:32]) ? 32'hFFFF_FFFF : r_d[31:0]);

	// stage payload
	always_ff @(posedge clk) begin
		if (en) begin
			// s1: first products
			ma_s1  <= x_d * cal.t2;
			mdd_s1 <= d_d * d_d;
			rp_s1  <= in_item.raw_pressure;
			// s2
			a_s2   <= a_d;
			mb_s2  <= $signed(dd_sh[19:0]) * cal.t3;
			rp_s2  <= rp_s1;
			// s3: fine temperature
			fine_s3 <= a_s2 + b_d;
			rp_s3   <= rp_s2;
			// s4: temperature out, pressure offset
			temp_s4 <= temp_d;
			v1_s4   <= v1_d;
			rp_s4   <= rp_s3;
			// s5: square and linear terms
			sq_s5   <= v1_s4 * v1_s4;
			m5_s5   <= v1_s4 * cal.p5;
			m2_s5   <= v1_s4 * cal.p2;
			temp_s5 <= temp_s4;
			rp_s5   <= rp_s4;
			// s6: square times p6 and p3, split in halves
			ml6_s6  <= $signed({1'b0, sq_s5[31:0]}) * cal.p6;
			mh6_s6  <= 32'($signed({1'b0, sq_s5[63:32]}) * cal.p6);
			ml3_s6  <= $signed({1'b0, sq_s5[31:0]}) * cal.p3;
			mh3_s6  <= 32'($signed({1'b0, sq_s5[63:32]}) * cal.p3);
			m5_s6   <= m5_s5;
			m2_s6   <= m2_s5;
			temp_s6 <= temp_s5;
			rp_s6   <= rp_s5;
			// s7: recombine
			v2_s7   <= {{15{ml6_s6[48]}}, ml6_s6} + {mh6_s6, 32'd0} +
				({{14{m5_s6[49]}}, m5_s6} << 17) + ({{48{cal.p4[15]}}, cal.p4} << 35);
			u3_s7   <= {{15{ml3_s6[48]}}, ml3_s6} + {mh3_s6, 32'd0};
			m2sh_s7 <= {{14{m2_s6[49]}}, m2_s6} << 12;
			temp_s7 <= temp_s6;
			rp_s7   <= rp_s6;
			// s8: divisor base and numerator base
			w_s8    <= u3_sh + m2sh_s7 + btpc_pkg::OFFSET_47;
			num_s8  <= {12'd0, p0_d, 31'd0} - v2_s7;
			temp_s8 <= temp_s7;
			// s9: scale by p1 and by the numerator constant
			wl_s9   <= w_s8[31:0] * cal.p1;
			wh_s9   <= 32'(w_s8[63:32] * cal.p1);
			nl_s9   <= num_s8[31:0] * btpc_pkg::DIV_SCALE;
			nh_s9   <= 32'(num_s8[63:32] * btpc_pkg::DIV_SCALE);
			temp_s9 <= temp_s8;
			// s10
			den_s10  <= $signed(wp_d) >>> 33;
			num_s10  <= {nh_s9, 32'd0} + {20'd0, nl_s9};
			temp_s10 <= temp_s9;
			// s11: magnitudes for the divider
			an_s11   <= num_s10[63] ? 64'd0 - num_s10 : num_s10;
			ad_s11   <= den_s10[63] ? 64'd0 - den_s10 : den_s10;
			side_s11 <= '{temp: temp_s10, zero: (den_s10 == 64'sd0),
				neg: num_s10[63] ^ den_s10[63]};
			// s12: signed quotient
			p_s12    <= p_d;
			qq_s12   <= qq_d;
			side_s12 <= dv_side;
			// s13
			lolo_s13 <= qq_s12[31:0] * qq_s12[31:0];
			hilo_s13 <= 32'(qq_s12[63:32] * qq_s12[31:0]);
			pl8_s13  <= $signed({1'b0, p_s12[31:0]}) * cal.p8;
			ph8_s13  <= 32'($signed({1'b0, p_s12[63:32]}) * cal.p8);
			p_s13    <= p_s12;
			side_s13 <= side_s12;
			// s14
			sqq_s14  <= lolo_s13 + {hilo_s13[30:0], 33'd0};
			v2p_s14  <= v2p_d;
			p_s14    <= p_s13;
			side_s14 <= side_s13;
			// s15
			l9_s15   <= $signed({1'b0, sqq_s14[31:0]}) * cal.p9;
			h9_s15   <= 32'($signed({1'b0, sqq_s14[63:32]}) * cal.p9);
			v2p_s15  <= v2p_s14;
			p_s15    <= p_s14;
			side_s15 <= side_s14;
			// s16
			v1p_s16  <= v1p_d;
			v2p_s16  <= v2p_s15;
			p_s16    <= p_s15;
			side_s16 <= side_s15;
			// s17
			sum_s17  <= p_s16 + v1p_s16 + v2p_s16;
			side_s17 <= side_s16;
			// output register
			out_temp   <= side_s17.temp;
			out_pres   <= side_s17.zero ? 32'd0 : sat_d;
			out_pvalid <= !side_s17.zero;
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11} <= '0;
			{v_s12, v_s13, v_s14, v_s15, v_s16, v_s17, out_v_q} <= '0;
		end else if (en) begin
			v_s1  <= in_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= dv_valid;
			v_s13 <= v_s12;
			v_s14 <= v_s13;
			v_s15 <= v_s14;
			v_s16 <= v_s15;
			v_s17 <= v_s16;
			out_v_q <= v_s17;
		end
	end

	btpc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s11),
		.in_num   (an_s11),
		.in_den   (ad_s11),
		.in_side  (side_s11),
		.out_valid(dv_valid),
		.out_quo  (dv_quo),
		.out_side (dv_side)
	);

	assign out_valid = out_v_q;

endmodule

FILE: src/baro_temp_pressure_compensation.sv
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation
// Integer temperature and pressure compensation of raw sensor readings.
//
//  channel   dir  signals                       contents
//  s_*       in   s_tvalid s_tready s_tdata     raw sample pair
//  m_*       out  m_tvalid m_tready m_tdata     temperature, pressure, flag
//  apb       in   psel penable pwrite paddr ... calibration words
//
// One sample pair per cycle sustained while the output is not held; the 64-stage
// divider yields one quotient bit per stage.
// Reset clears the queue, stage valids and calibration registers.
// A held output stalls the whole datapath; the two-entry input queue keeps
// accepting until full.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // raw_temperature[19:0], raw_pressure[39:20]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // temperature_centi[31:0], pressure_q24_8[63:32]
	output logic [0:0]  m_tuser,   // pressure_valid[0]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [btpc_pkg::ADDR_W-1:0] paddr,
	input  logic [btpc_pkg::DATA_W-1:0] pwdata,
	output logic [btpc_pkg::DATA_W-1:0] prdata,
	output logic        pready
);

	logic [15:0]      cal_t1_q;
	logic [31:0]      cal_t2_t3_q;
	logic [15:0]      cal_p1_q;
	logic [31:0]      cal_p2_p3_q;
	logic [31:0]      cal_p4_p5_q;
	logic [31:0]      cal_p6_p7_q;
	logic [31:0]      cal_p8_p9_q;
	logic             wr_en;
	btpc_pkg::cal_t   cal;
	btpc_pkg::item_t  in_item;
	btpc_pkg::item_t  head_item;
	logic             head_valid;
	logic             take;
	logic [31:0]      temp;
	logic [31:0]      pres;
	logic             pvalid;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	// calibration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_t1_q    <= '0;
			cal_t2_t3_q <= '0;
			cal_p1_q    <= '0;
			cal_p2_p3_q <= '0;
			cal_p4_p5_q <= '0;
			cal_p6_p7_q <= '0;
			cal_p8_p9_q <= '0;
		end else if (wr_en) begin
			unique case (btpc_pkg::reg_idx_t'(paddr[4:2]))
				btpc_pkg::REG_T1:    cal_t1_q    <= pwdata[15:0];
				btpc_pkg::REG_T2_T3: cal_t2_t3_q <= pwdata;
				btpc_pkg::REG_P1:    cal_p1_q    <= pwdata[15:0];
				btpc_pkg::REG_P2_P3: cal_p2_p3_q <= pwdata;
				btpc_pkg::REG_P4_P5: cal_p4_p5_q <= pwdata;
				btpc_pkg::REG_P6_P7: cal_p6_p7_q <= pwdata;
				btpc_pkg::REG_P8_P9: cal_p8_p9_q <= pwdata;
				default: ;
			endcase
		end
	end

	// register read back
	always_comb begin
		unique case (btpc_pkg::reg_idx_t'(paddr[4:2]))
			btpc_pkg::REG_T1:    prdata = {16'd0, cal_t1_q};
			btpc_pkg::REG_T2_T3: prdata = cal_t2_t3_q;
			btpc_pkg::REG_P1:    prdata = {16'd0, cal_p1_q};
			btpc_pkg::REG_P2_P3: prdata = cal_p2_p3_q;
			btpc_pkg::REG_P4_P5: prdata = cal_p4_p5_q;
			btpc_pkg::REG_P6_P7: prdata = cal_p6_p7_q;
			btpc_pkg::REG_P8_P9: prdata = cal_p8_p9_q;
			default:             prdata = '0;
		endcase
	end

	// calibration words as signed fields
	assign cal.t1 = cal_t1_q;
	assign cal.t2 = $signed(cal_t2_t3_q[15:0]);
	assign cal.t3 = $signed(cal_t2_t3_q[31:16]);
	assign cal.p1 = cal_p1_q;
	assign cal.p2 = $signed(cal_p2_p3_q[15:0]);
	assign cal.p3 = $signed(cal_p2_p3_q[31:16]);
	assign cal.p4 = $signed(cal_p4_p5_q[15:0]);
	assign cal.p5 = $signed(cal_p4_p5_q[31:16]);
	assign cal.p6 = $signed(cal_p6_p7_q[15:0]);
	assign cal.p7 = $signed(cal_p6_p7_q[31:16]);
	assign cal.p8 = $signed(cal_p8_p9_q[15:0]);
	assign cal.p9 = $signed(cal_p8_p9_q[31:16]);

	assign in_item.raw_temperature = s_tdata[19:0];
	assign in_item.raw_pressure    = s_tdata[39:20];

	btpc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_item   (in_item),
		.take      (take),
		.head_valid(head_valid),
		.head_item (head_item)
	);

	btpc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cal       (cal),
		.in_valid  (head_valid),
		.in_item   (head_item),
		.take      (take),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_temp  (temp),
		.out_pres  (pres),
		.out_pvalid(pvalid)
	);

	assign m_tdata = {pres, temp};
	assign m_tuser = pvalid;

endmodule

FILE: src/btpc_checker.sv
// ----------------------------------------------------------------------------
// btpc_checker
// Port-level checks on the output stream and configuration port.
// ----------------------------------------------------------------------------
`include "baro_temp_pressure_compensation_macros.svh"

module btpc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic [0:0]  m_tuser,
	input logic        pready
);

	// stalled result holds
	`BTPC_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// result only withdrawn after its transaction
	`BTPC_ASSERT(a_out_drop, $fell(m_tvalid) |-> $past(m_tready))

	// zero divisor forces zero pressure
	`BTPC_NEVER(a_inval_zero, m_tvalid && !m_tuser[0] && (m_tdata[63:32] != 32'd0))

	// config port never waits
	`BTPC_ASSERT(a_pready, pready)

endmodule

bind baro_temp_pressure_compensation btpc_checker u_chk (.*);
